// ===== sv/rgbhpc_pkg.sv =====
package rgbhpc_pkg;

   localparam int CHAN_W              = 8;
   localparam int GAIN_W              = 12;
   localparam int PROD_W              = CHAN_W + GAIN_W;
   localparam int NUM_CHAN            = 3;
   localparam int QUOT_W              = CHAN_W;
   localparam int WORK_W              = 2 * CHAN_W;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // channel slots inside the per-pixel arrays
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [GAIN_W-1:0] gain_type;
   typedef logic [PROD_W-1:0] prod_type;

   localparam gain_type GAIN_RESET = gain_type'(256);
   // largest product that still takes the plain rule: 255 * 256
   localparam prod_type LIMIT_Q8   = prod_type'(255 * 256);

   typedef struct packed {
      chan_type red_in;
      chan_type green_in;
      chan_type blue_in;
      logic     last_in;
   } req_payload_type;

   typedef struct packed {
      chan_type red_out;
      chan_type green_out;
      chan_type blue_out;
      logic     last_out;
   } rsp_payload_type;

   // one classified pixel waiting for the back end
   typedef struct packed {
      logic                    last;
      logic                    clamp;
      chan_type                cmax;
      chan_type [NUM_CHAN-1:0] chan;
      chan_type [NUM_CHAN-1:0] plain;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

// ===== sv/rgbhpc_chan_if.sv =====
interface rgbhpc_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/rgbhpc_front.sv =====
module rgbhpc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  rgbhpc_pkg::gain_type gain,
   rgbhpc_chan_if.sink          req_if,
   input  logic                 room,
   output rgbhpc_pkg::push_type push
);
   import rgbhpc_pkg::*;

   logic            valid_ff, valid_in;
   req_payload_type pix_ff;
   chan_type        cmax_ff, cmax_in;
   prod_type        prod [NUM_CHAN];
   prod_type        pmax;
   entry_type       entry;

   // hold the beat until the queue has room
   assign req_if.ready = !valid_ff || room;
   assign valid_in     = req_if.ready ? req_if.valid : valid_ff;

   always_comb begin
      cmax_in = req_if.payload.red_in;
      if (req_if.payload.green_in > cmax_in) begin
         cmax_in = req_if.payload.green_in;
      end
      if (req_if.payload.blue_in > cmax_in) begin
         cmax_in = req_if.payload.blue_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         pix_ff  <= req_if.payload;
         cmax_ff <= cmax_in;
      end
   end

   always_comb begin
      prod[CH_RED]   = prod_type'(pix_ff.red_in) * prod_type'(gain);
      prod[CH_GREEN] = prod_type'(pix_ff.green_in) * prod_type'(gain);
      prod[CH_BLUE]  = prod_type'(pix_ff.blue_in) * prod_type'(gain);
      pmax           = prod_type'(cmax_ff) * prod_type'(gain);

      entry.last            = pix_ff.last_in;
      entry.clamp           = (pmax > LIMIT_Q8);
      entry.cmax            = cmax_ff;
      entry.chan[CH_RED]    = pix_ff.red_in;
      entry.chan[CH_GREEN]  = pix_ff.green_in;
      entry.chan[CH_BLUE]   = pix_ff.blue_in;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         entry.plain[ch] = prod[ch][2*CHAN_W-1:CHAN_W];
      end
   end

   assign push.valid = valid_ff;
   assign push.entry = entry;

endmodule

// ===== sv/rgbhpc_queue.sv =====
module rgbhpc_queue #(
   parameter int DEPTH = rgbhpc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rgbhpc_pkg::push_type push,
   output logic                 room,
   input  logic                 pop,
   output rgbhpc_pkg::head_type head
);
   import rgbhpc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;

   assign room    = (count_ff < CNT_W'(DEPTH));
   assign do_push = push.valid && room;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

endmodule

// ===== sv/rgbhpc_back.sv =====
module rgbhpc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  rgbhpc_pkg::head_type head,
   output logic                 pop,
   rgbhpc_chan_if.source        rsp_if
);
   import rgbhpc_pkg::*;

   localparam int STAGES = QUOT_W;

   typedef logic [WORK_W-1:0] work_type;

   typedef struct packed {
      logic                    last;
      logic                    clamp;
      chan_type                divisor;
      chan_type [NUM_CHAN-1:0] plain;
      work_type [NUM_CHAN-1:0] work;
   } stage_type;

   logic            pipe_valid_ff [STAGES];
   stage_type       pipe_ff       [STAGES];
   stage_type       stage_in      [STAGES];
   stage_type       last_step;
   logic            out_valid_ff;
   rsp_payload_type out_ff, out_in;
   logic            advance;

   // one restoring step: remainder in the upper half, quotient shifts in below
   function automatic work_type div_step(input work_type w, input chan_type d);
      logic [CHAN_W:0] trial;
      logic [CHAN_W:0] diff;
      begin
         trial = w[WORK_W-1:CHAN_W-1];
         diff  = trial - {1'b0, d};
         if (trial >= {1'b0, d}) begin
            div_step = {diff[CHAN_W-1:0], w[CHAN_W-2:0], 1'b1};
         end else begin
            div_step = {trial[CHAN_W-1:0], w[CHAN_W-2:0], 1'b0};
         end
      end
   endfunction

   function automatic stage_type step_stage(input stage_type s);
      stage_type r;
      begin
         r = s;
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            r.work[ch] = div_step(s.work[ch], s.divisor);
         end
         step_stage = r;
      end
   endfunction

   assign advance = !out_valid_ff || rsp_if.ready;
   assign pop     = advance && head.valid;

   always_comb begin
      stage_in[0].last    = head.entry.last;
      stage_in[0].clamp   = head.entry.clamp;
      stage_in[0].divisor = head.entry.cmax;
      stage_in[0].plain   = head.entry.plain;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         // 255 * c
         stage_in[0].work[ch] = {head.entry.chan[ch], CHAN_W'(0)}
                                - {CHAN_W'(0), head.entry.chan[ch]};
      end
      for (int k = 1; k < STAGES; k++) begin
         stage_in[k] = step_stage(pipe_ff[k-1]);
      end
      last_step = step_stage(pipe_ff[STAGES-1]);

      out_in.red_out   = last_step.clamp ? last_step.work[CH_RED][QUOT_W-1:0]
                                         : last_step.plain[CH_RED];
      out_in.green_out = last_step.clamp ? last_step.work[CH_GREEN][QUOT_W-1:0]
                                         : last_step.plain[CH_GREEN];
      out_in.blue_out  = last_step.clamp ? last_step.work[CH_BLUE][QUOT_W-1:0]
                                         : last_step.plain[CH_BLUE];
      out_in.last_out  = last_step.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            pipe_valid_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         pipe_valid_ff[0] <= head.valid;
         for (int k = 1; k < STAGES; k++) begin
            pipe_valid_ff[k] <= pipe_valid_ff[k-1];
         end
         out_valid_ff <= pipe_valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < STAGES; k++) begin
            pipe_ff[k] <= stage_in[k];
         end
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_ff;

endmodule

// ===== sv/rgb_gain_hue_preserving_clamp_core.sv =====
// A pixel beat passes the front register, the queue, the divider pipeline and the output
//   register, in that order, before it shows on rsp_if.
// Throughput: one pixel per clock while rsp_if takes beats; the divider is an 8-stage
//   pipeline, one quotient bit per stage in all three channels, a new pixel per cycle.
// Reset: synchronous, active high; empties front, queue, divider pipeline and output
//   register and sets the gain to 1.0 (256).
module rgb_gain_hue_preserving_clamp_core #(
   parameter int QUEUE_DEPTH = rgbhpc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   rgbhpc_chan_if.sink   req_if,
   rgbhpc_chan_if.source rsp_if,
   rgbhpc_chan_if.sink   csr_if
);
   import rgbhpc_pkg::*;

   // Gain register. Always ready; write it only while the datapath is idle,
   // so no pixel ever sees a gain change mid-flight.
   gain_type gain_ff, gain_in;
   push_type q_push;
   head_type q_head;
   logic     q_room;
   logic     q_pop;

   assign csr_if.ready = 1'b1;
   assign gain_in      = csr_if.valid ? csr_if.payload : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   // Front: register the beat, form c*gain per channel, decide whether the
   // brightest product exceeds 255.0 in 8.8 and needs the hue-preserving clamp.
   rgbhpc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .gain   (gain_ff),
      .req_if (req_if),
      .room   (q_room),
      .push   (q_push)
   );

   // Short queue: lets the front keep taking beats while the output stalls.
   rgbhpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .room  (q_room),
      .pop   (q_pop),
      .head  (q_head)
   );

   // Back: since p/pmax == c/cmax, the clamped value is floor(255*c/cmax);
   // divide in a bit-per-stage pipeline and select against the plain p>>8.
   rgbhpc_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (q_head),
      .pop    (q_pop),
      .rsp_if (rsp_if)
   );

   // Gain comes out of reset at 1.0.
   a_gain_reset: assert property (@(posedge clock)
      $fell(reset) |-> gain_ff == GAIN_RESET)
      else $error("gain not at reset value after reset");

   // A clamped pixel must never reach the divider with a zero divisor.
   a_clamp_divisor: assert property (@(posedge clock) disable iff (reset)
      (q_head.valid && q_head.entry.clamp) |-> q_head.entry.cmax != '0)
      else $error("clamp entry with zero divisor");

   // The divisor is the largest channel, so every quotient stays within 8 bits.
   a_cmax_is_max: assert property (@(posedge clock) disable iff (reset)
      q_head.valid |-> (q_head.entry.cmax >= q_head.entry.chan[CH_RED] &&
                        q_head.entry.cmax >= q_head.entry.chan[CH_GREEN] &&
                        q_head.entry.cmax >= q_head.entry.chan[CH_BLUE]))
      else $error("queued cmax is not the channel maximum");

   // Never pop an empty queue.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head.valid)
      else $error("pop from empty queue");

endmodule
